[rtl/core/pdnc_pkg.sv]
// Shared types, constants and the divide step for the perspective divide unit.
// No dependencies; used by every module under rtl/core.
package pdnc_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned NumBits = DataW;
	localparam int unsigned AddrW   = 4;

	localparam logic [DataW-1:0] XSentinel = 32'hFFFF_EC78;  // -5000
	localparam logic [DataW-1:0] XNudge    = 32'hFFFF_EC77;  // -5001
	localparam logic [DataW-1:0] SatMax    = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		REG_DEPTH_OFFSET = 2'd0,
		REG_NEAR_LIMIT   = 2'd1,
		REG_CLIP_ENABLE  = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	// side info riding along with each vertex through the divider
	typedef struct packed {
		logic             clip;
		logic             dz;
		logic             clip_en;
		logic             neg_x;
		logic             neg_y;
		logic             last;
		logic [DataW-1:0] depth;
	} meta_t;

	typedef struct packed {
		logic [DataW-1:0] dsr;
		logic [DataW-1:0] rem_x;
		logic [DataW-1:0] dvd_x;
		logic [DataW-1:0] rem_y;
		logic [DataW-1:0] dvd_y;
		meta_t            meta;
	} beat_t;

	typedef struct packed {
		logic [DataW-1:0] rem;
		logic [DataW-1:0] dvd;
	} step_t;

	// one restoring step: quotient bit shifts in at the bottom of dvd
	function automatic step_t div_step(input logic [DataW-1:0] rem,
					   input logic [DataW-1:0] dvd,
					   input logic [DataW-1:0] dsr);
		logic [DataW:0] part;
		logic [DataW:0] trial;
		step_t          res;
		part  = {rem, dvd[DataW-1]};
		trial = part - {1'b0, dsr};
		if (!trial[DataW]) begin
			res.rem = trial[DataW-1:0];
			res.dvd = {dvd[DataW-2:0], 1'b1};
		end else begin
			res.rem = part[DataW-1:0];
			res.dvd = {dvd[DataW-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

[rtl/core/pdnc_prep.sv]
// Front end: near test, depth offset, operand magnitudes and signs.
// Depends on pdnc_pkg.
module pdnc_prep import pdnc_pkg::*; (
	input  logic [DataW-1:0] depth_in,
	input  logic [DataW-1:0] x_in,
	input  logic [DataW-1:0] y_in,
	input  logic             last_in,
	input  logic [DataW-1:0] depth_offset,
	input  logic [DataW-1:0] near_limit,
	input  logic             clip_enable,
	output beat_t            beat
);
	logic             clip;
	logic [DataW-1:0] abs_z;

	assign clip  = clip_enable && ($signed(depth_in) < $signed(near_limit));
	assign abs_z = depth_in[DataW-1] ? (~depth_in + 1'b1) : depth_in;

	always_comb begin
		beat.rem_x = '0;
		beat.rem_y = '0;
		beat.dvd_x = x_in[DataW-1] ? (~x_in + 1'b1) : x_in;
		beat.dvd_y = y_in[DataW-1] ? (~y_in + 1'b1) : y_in;
		// clipped vertex: divide y by one so it comes out unchanged
		beat.dsr   = clip ? {{(DataW-1){1'b0}}, 1'b1} : abs_z;
		beat.meta.clip    = clip;
		beat.meta.dz      = !clip && (depth_in == '0);
		beat.meta.clip_en = clip_enable;
		beat.meta.neg_x   = x_in[DataW-1] ^ depth_in[DataW-1];
		beat.meta.neg_y   = clip ? y_in[DataW-1] : (y_in[DataW-1] ^ depth_in[DataW-1]);
		beat.meta.last    = last_in;
		beat.meta.depth   = depth_in - depth_offset;
	end
endmodule

[rtl/core/pdnc_cell.sv]
// One divider cell: a quotient bit for x and for y, then a register.
// Depends on pdnc_pkg; instantiated once per quotient bit.
module pdnc_cell import pdnc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_move,
	input  beat_t up_beat,
	output logic  dn_valid,
	input  logic  dn_move,
	output beat_t dn_beat
);
	logic  valid_q;
	beat_t beat_q;
	step_t sx;
	step_t sy;

	// a cell takes a new beat when empty or when its content moves on
	assign up_move  = !valid_q || dn_move;
	assign dn_valid = valid_q;
	assign dn_beat  = beat_q;

	always_comb begin
		sx = div_step(up_beat.rem_x, up_beat.dvd_x, up_beat.dsr);
		sy = div_step(up_beat.rem_y, up_beat.dvd_y, up_beat.dsr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_move) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_move && up_valid) begin
			beat_q.dsr   <= up_beat.dsr;
			beat_q.rem_x <= sx.rem;
			beat_q.dvd_x <= sx.dvd;
			beat_q.rem_y <= sy.rem;
			beat_q.dvd_y <= sy.dvd;
			beat_q.meta  <= up_beat.meta;
		end
	end
endmodule

[rtl/core/pdnc_out.sv]
// Back end: sign restore, overflow saturation, sentinel and nudge, output register.
// Depends on pdnc_pkg.
module pdnc_out import pdnc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_move,
	input  beat_t            up_beat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DataW-1:0] out_x,
	output logic [DataW-1:0] out_y,
	output logic [DataW-1:0] out_depth,
	output logic             clipped,
	output logic             div_by_zero,
	output logic             last_out
);
	logic             valid_q;
	logic [DataW-1:0] qx;
	logic [DataW-1:0] qy;
	logic [DataW-1:0] fx;
	logic [DataW-1:0] fy;
	logic [DataW-1:0] x_q;
	logic [DataW-1:0] y_q;
	meta_t            meta_q;

	assign up_move = !valid_q || out_ready;

	always_comb begin
		qx = up_beat.meta.neg_x ? (~up_beat.dvd_x + 1'b1) : up_beat.dvd_x;
		qy = up_beat.meta.neg_y ? (~up_beat.dvd_y + 1'b1) : up_beat.dvd_y;
		// only -2^31 / -1 gives a positive magnitude of 2^31
		if (!up_beat.meta.neg_x && up_beat.dvd_x[DataW-1]) qx = SatMax;
		if (!up_beat.meta.neg_y && up_beat.dvd_y[DataW-1]) qy = SatMax;
		if (up_beat.meta.clip) begin
			fx = XSentinel;
			fy = qy;
		end else if (up_beat.meta.dz) begin
			fx = '0;
			fy = '0;
		end else begin
			fx = (up_beat.meta.clip_en && qx == XSentinel) ? XNudge : qx;
			fy = qy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_move) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_move && up_valid) begin
			x_q    <= fx;
			y_q    <= fy;
			meta_q <= up_beat.meta;
		end
	end

	assign out_valid   = valid_q;
	assign out_x       = x_q;
	assign out_y       = y_q;
	assign out_depth   = meta_q.depth;
	assign clipped     = meta_q.clip;
	assign div_by_zero = meta_q.dz;
	assign last_out    = meta_q.last;
endmodule

[rtl/core/perspective_divide_near_clip_unit.sv]
// Perspective divide with near-plane clip. Top level: APB registers, front end,
// a chain of pdnc_cell dividers and the output stage. Depends on pdnc_pkg.
//
// Accepts one vertex per cycle while in_ready is high and returns one result
// per vertex in order. A vertex passes through one cell per quotient bit
// (32 cells, each dividing x and y by |depth| one bit) and then the output
// register. Each stage holds its own valid bit, so empty stages are filled
// while a result waits at the output; throughput is one beat per cycle as long
// as out_ready stays high. Registers: 0x0 depth_offset, 0x4 near_limit,
// 0x8 clip_enable (bit 0); write them only while the unit is empty.
module perspective_divide_near_clip_unit import pdnc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [DataW-1:0] depth_in,
	input  logic [DataW-1:0] x_in,
	input  logic [DataW-1:0] y_in,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DataW-1:0] out_x,
	output logic [DataW-1:0] out_y,
	output logic [DataW-1:0] out_depth,
	output logic             clipped,
	output logic             div_by_zero,
	output logic             last_out
);
	logic [DataW-1:0] depth_offset_q;
	logic [DataW-1:0] near_limit_q;
	logic             clip_enable_q;
	reg_idx_t         idx;
	logic             wr;

	beat_t stg [0:NumBits];
	logic  vld [0:NumBits];
	logic  mv  [0:NumBits];

	// register port
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_offset_q <= '0;
			near_limit_q   <= {{(DataW-1){1'b0}}, 1'b1};
			clip_enable_q  <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_DEPTH_OFFSET: depth_offset_q <= pwdata;
				REG_NEAR_LIMIT:   near_limit_q   <= pwdata;
				REG_CLIP_ENABLE:  clip_enable_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEPTH_OFFSET: prdata = depth_offset_q;
			REG_NEAR_LIMIT:   prdata = near_limit_q;
			REG_CLIP_ENABLE:  prdata = {{(DataW-1){1'b0}}, clip_enable_q};
			default:          prdata = '0;
		endcase
	end

	// datapath
	pdnc_prep u_prep (
		.depth_in     (depth_in),
		.x_in         (x_in),
		.y_in         (y_in),
		.last_in      (last_in),
		.depth_offset (depth_offset_q),
		.near_limit   (near_limit_q),
		.clip_enable  (clip_enable_q),
		.beat         (stg[0])
	);

	assign vld[0]   = in_valid;
	assign in_ready = mv[0];

	for (genvar i = 0; i < NumBits; i++) begin : g_cell
		pdnc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_move  (mv[i]),
			.up_beat  (stg[i]),
			.dn_valid (vld[i+1]),
			.dn_move  (mv[i+1]),
			.dn_beat  (stg[i+1])
		);
	end

	pdnc_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (vld[NumBits]),
		.up_move     (mv[NumBits]),
		.up_beat     (stg[NumBits]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_depth   (out_depth),
		.clipped     (clipped),
		.div_by_zero (div_by_zero),
		.last_out    (last_out)
	);
endmodule
